// ----- src/iatp_pkg.sv -----
// Package for the IP address text parser: phase codes, status codes, constants.
// Used by iatp_step and ip_address_text_parser. No dependencies.
package iatp_pkg;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_SCAN     = 4'd1,
    PH_V4_FIRST = 4'd2,
    PH_V4_ZERO  = 4'd3,
    PH_V4_DEC   = 4'd4,
    PH_V4_HEX0  = 4'd5,
    PH_V4_HEX   = 4'd6,
    PH_V6_BEGIN = 4'd7,
    PH_V6_LEAD  = 4'd8,
    PH_V6_WORD  = 4'd9,
    PH_V6_SEP   = 4'd10,
    PH_V6_GAP   = 4'd11
  } phase_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [3:0] NO_GAP = 4'd15;
  localparam logic [8:0] DEC_SAT = 9'd256;
  localparam logic [16:0] HEX_SAT = 17'h10000;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_RBR   = 8'h5d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic APB_ADDR_ALLOW_V6 = 1'b0;

  typedef struct packed {
    phase_e        phase;
    logic          bracketed;
    logic [127:0]  words;
    logic [3:0]    word_count;
    logic [3:0]    gap_pos;
    logic [8:0]    dec_acc;
    logic [16:0]   hex_acc;
    logic [1:0]    octet_idx;
    logic [31:0]   quad;
  } parse_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_ipv6;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic        byte_consumed;
  } result_t;

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return 5'd16;
  endfunction

  function automatic logic [8:0] dec_add(input logic [8:0] acc, input logic [3:0] d);
    logic [12:0] v;
    v = 13'({acc, 3'b000}) + 13'({acc, 1'b0}) + 13'(d);
    return (v > 13'(DEC_SAT)) ? DEC_SAT : v[8:0];
  endfunction

  function automatic logic [16:0] hex_add(input logic [16:0] acc, input logic [3:0] h);
    logic [20:0] v;
    v = {acc, 4'b0000} | 21'(h);
    return (v > 21'(HEX_SAT)) ? HEX_SAT : v[16:0];
  endfunction

endpackage

// ----- src/iatp_step.sv -----
// Next-state and result logic for one text byte of the address parser.
// Depends on iatp_pkg.
module iatp_step (
  input  iatp_pkg::parse_t  cur_i,
  input  logic              allow_v6_i,
  input  logic [7:0]        c_i,
  input  logic              end_i,
  output iatp_pkg::parse_t  nxt_o,
  output logic              emit_o,
  output iatp_pkg::result_t res_o
);

  iatp_pkg::parse_t clr;

  always_comb begin
    clr = '0;
    clr.phase = iatp_pkg::PH_START;
    clr.gap_pos = iatp_pkg::NO_GAP;
  end

  always_comb begin
    logic [4:0]  h;
    logic        dig, hx, gap, full, st_v6, oct_end, w_end, w_start, v4f, do_v6;
    logic        v6_used;
    logic [16:0] oct_v;
    logic [3:0]  n, wc1, hi;
    logic [15:0] w [8];
    logic [15:0] ws [8];
    logic [31:0] q;
    nxt_o  = cur_i;
    emit_o = 1'b0;
    res_o  = '0;
    h   = iatp_pkg::hex_of(c_i);
    dig = !end_i && h < 5'd10 && c_i[7:4] == 4'h3;
    hx  = !end_i && !h[4];
    oct_end = 1'b0; w_end = 1'b0; w_start = 1'b0; v4f = 1'b0; do_v6 = 1'b0;
    v6_used = 1'b0;
    oct_v = '0;
    unique case (cur_i.phase)
      iatp_pkg::PH_START: begin
        if (!allow_v6_i) v4f = 1'b1;
        else if (!end_i && c_i == iatp_pkg::CH_LBR) begin
          nxt_o.bracketed = 1'b1;
          nxt_o.phase = iatp_pkg::PH_V6_BEGIN;
        end
      end
      iatp_pkg::PH_V4_FIRST: v4f = 1'b1;
      iatp_pkg::PH_V4_ZERO: begin
        if (!end_i && c_i == iatp_pkg::CH_X) begin
          nxt_o.hex_acc = '0;
          nxt_o.phase = iatp_pkg::PH_V4_HEX0;
        end else if (dig) begin
          nxt_o.dec_acc = 9'(c_i[3:0]);
          nxt_o.phase = iatp_pkg::PH_V4_DEC;
        end else oct_end = 1'b1;
      end
      iatp_pkg::PH_V4_DEC: begin
        if (dig) nxt_o.dec_acc = iatp_pkg::dec_add(cur_i.dec_acc, c_i[3:0]);
        else begin oct_end = 1'b1; oct_v = 17'(cur_i.dec_acc); end
      end
      iatp_pkg::PH_V4_HEX0: begin
        if (!hx) begin emit_o = 1'b1; res_o.status = iatp_pkg::ST_SYNTAX; end
        else begin
          nxt_o.hex_acc = 17'(h[3:0]);
          nxt_o.phase = iatp_pkg::PH_V4_HEX;
        end
      end
      iatp_pkg::PH_V4_HEX: begin
        if (hx) nxt_o.hex_acc = iatp_pkg::hex_add(cur_i.hex_acc, h[3:0]);
        else begin oct_end = 1'b1; oct_v = cur_i.hex_acc; end
      end
      iatp_pkg::PH_V6_BEGIN: begin
        if (!end_i && c_i == iatp_pkg::CH_COLON) nxt_o.phase = iatp_pkg::PH_V6_LEAD;
        else w_start = 1'b1;
      end
      iatp_pkg::PH_V6_LEAD: begin
        if (end_i || c_i != iatp_pkg::CH_COLON) begin
          emit_o = 1'b1; res_o.status = iatp_pkg::ST_SYNTAX;
        end else begin
          nxt_o.gap_pos = '0;
          nxt_o.phase = iatp_pkg::PH_V6_GAP;
        end
      end
      iatp_pkg::PH_V6_WORD: begin
        if (hx) nxt_o.hex_acc = iatp_pkg::hex_add(cur_i.hex_acc, h[3:0]);
        else w_end = 1'b1;
      end
      iatp_pkg::PH_V6_SEP: begin
        if (end_i || (c_i == iatp_pkg::CH_COLON && cur_i.gap_pos < 4'd8)) begin
          emit_o = 1'b1; res_o.status = iatp_pkg::ST_SYNTAX;
        end else if (c_i == iatp_pkg::CH_COLON) begin
          nxt_o.gap_pos = cur_i.word_count;
          nxt_o.phase = iatp_pkg::PH_V6_GAP;
        end else w_start = 1'b1;
      end
      iatp_pkg::PH_V6_GAP: begin
        if (end_i) begin
          if (!cur_i.bracketed) do_v6 = 1'b1;
          else begin emit_o = 1'b1; res_o.status = iatp_pkg::ST_SYNTAX; end
        end else if (c_i == iatp_pkg::CH_RBR && cur_i.bracketed) begin
          do_v6 = 1'b1; v6_used = 1'b1;
        end else w_start = 1'b1;
      end
      iatp_pkg::PH_SCAN: ;
      default: nxt_o = clr;
    endcase

    // unframed scan, shared by start (IPv6 allowed, not '[') and scan phases
    st_v6 = (cur_i.phase == iatp_pkg::PH_START && allow_v6_i &&
             !(!end_i && c_i == iatp_pkg::CH_LBR)) || cur_i.phase == iatp_pkg::PH_SCAN;
    if (st_v6) begin
      if (end_i) begin emit_o = 1'b1; res_o.status = iatp_pkg::ST_SYNTAX; end
      else if (dig) begin
        nxt_o.dec_acc = iatp_pkg::dec_add(cur_i.dec_acc, c_i[3:0]);
        nxt_o.hex_acc = iatp_pkg::hex_add(cur_i.hex_acc, h[3:0]);
        nxt_o.phase = iatp_pkg::PH_SCAN;
      end else if (hx) begin
        nxt_o.hex_acc = iatp_pkg::hex_add(cur_i.hex_acc, h[3:0]);
        nxt_o.phase = iatp_pkg::PH_V6_WORD;
      end else if (c_i == iatp_pkg::CH_COLON) begin
        if (cur_i.phase == iatp_pkg::PH_SCAN) w_end = 1'b1;
        else nxt_o.phase = iatp_pkg::PH_V6_LEAD;
      end else if (c_i == iatp_pkg::CH_DOT && cur_i.phase == iatp_pkg::PH_SCAN) begin
        oct_end = 1'b1; oct_v = 17'(cur_i.dec_acc);
      end else begin emit_o = 1'b1; res_o.status = iatp_pkg::ST_SYNTAX; end
    end

    if (v4f) begin
      if (!dig) begin emit_o = 1'b1; res_o.status = iatp_pkg::ST_SYNTAX; end
      else begin
        nxt_o.dec_acc = 9'(c_i[3:0]);
        nxt_o.phase = (c_i == iatp_pkg::CH_ZERO) ? iatp_pkg::PH_V4_ZERO
                                                 : iatp_pkg::PH_V4_DEC;
      end
    end

    if (w_start) begin
      if (!hx) begin emit_o = 1'b1; res_o.status = iatp_pkg::ST_SYNTAX; end
      else begin
        nxt_o.hex_acc = 17'(h[3:0]);
        nxt_o.phase = iatp_pkg::PH_V6_WORD;
      end
    end

    q = cur_i.quad;
    if (oct_end) begin
      unique case (cur_i.octet_idx)
        2'd0: q[31:24] = q[31:24] | oct_v[7:0];
        2'd1: q[23:16] = q[23:16] | oct_v[7:0];
        2'd2: q[15:8]  = q[15:8]  | oct_v[7:0];
        default: q[7:0] = q[7:0] | oct_v[7:0];
      endcase
      emit_o = 1'b1;
      if (oct_v > 17'd255) res_o.status = iatp_pkg::ST_RANGE;
      else if (cur_i.octet_idx == 2'd3) begin
        res_o.status = iatp_pkg::ST_OK;
        res_o.addr_lower = {32'd0, q};
      end else if (end_i || c_i != iatp_pkg::CH_DOT) res_o.status = iatp_pkg::ST_SYNTAX;
      else begin
        emit_o = 1'b0;
        nxt_o.quad = q;
        nxt_o.octet_idx = cur_i.octet_idx + 2'd1;
        nxt_o.phase = iatp_pkg::PH_V4_FIRST;
      end
    end

    gap = cur_i.gap_pos < 4'd8;
    wc1 = cur_i.word_count + 4'd1;
    full = wc1 == 4'd8;
    for (int i = 0; i < 8; i++) ws[i] = cur_i.words[16*(7-i) +: 16];
    if (w_end) begin
      emit_o = 1'b1;
      if (cur_i.hex_acc > 17'hFFFF) res_o.status = iatp_pkg::ST_RANGE;
      else if (cur_i.word_count >= 4'd8 || (gap && cur_i.word_count >= 4'd7))
        res_o.status = iatp_pkg::ST_SYNTAX;
      else begin
        ws[cur_i.word_count[2:0]] = cur_i.hex_acc[15:0];
        nxt_o.word_count = wc1;
        if (end_i) begin
          if (!cur_i.bracketed && (full || gap)) do_v6 = 1'b1;
          else res_o.status = iatp_pkg::ST_SYNTAX;
        end else if (c_i == iatp_pkg::CH_RBR && cur_i.bracketed && (full || gap)) begin
          do_v6 = 1'b1; v6_used = 1'b1;
        end else if (full || c_i != iatp_pkg::CH_COLON) res_o.status = iatp_pkg::ST_SYNTAX;
        else begin
          emit_o = 1'b0;
          nxt_o.phase = iatp_pkg::PH_V6_SEP;
        end
      end
      for (int i = 0; i < 8; i++) nxt_o.words[16*(7-i) +: 16] = ws[i];
    end

    n = w_end ? wc1 : cur_i.word_count;
    if (n > 4'd8) n = 4'd8;
    hi = 4'd8 - (n - cur_i.gap_pos);
    for (int i = 0; i < 8; i++) begin
      if (!gap || 4'(i) < cur_i.gap_pos) w[i] = ws[i];
      else if (4'(i) >= hi) w[i] = ws[3'(4'(i) - (4'd8 - n))];
      else w[i] = '0;
    end
    if (do_v6) begin
      emit_o = 1'b1;
      res_o.status = iatp_pkg::ST_OK;
      res_o.is_ipv6 = 1'b1;
      res_o.addr_upper = {w[0], w[1], w[2], w[3]};
      res_o.addr_lower = {w[4], w[5], w[6], w[7]};
      res_o.byte_consumed = v6_used;
    end

    if (emit_o) nxt_o = clr;
  end

endmodule

// ----- src/ip_address_text_parser.sv -----
// IP address text parser, top level: handshake, parse state register, APB register.
// Depends on iatp_pkg and iatp_step.
// A result is registered and appears in the cycle after the deciding byte is accepted.
// One byte per cycle unless a result stalls; the single parse state register sets it.
// The result register holds a pending result while accepting the next byte when drained.
// Reset: asynchronous, active low; parser at start of address, allow_ipv6 set.
module ip_address_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_mark_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        is_ipv6_o,
  output logic [63:0] addr_upper_o,
  output logic [63:0] addr_lower_o,
  output logic        byte_consumed_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  iatp_pkg::parse_t  parse_q, parse_d;
  iatp_pkg::result_t res_q, res_d;
  logic              out_valid_q;
  logic              allow_v6_q;
  logic              emit;
  logic              in_take;

  // Accept a byte whenever the result slot is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_take    = in_valid_i && in_ready_o;

  iatp_step u_step (
    .cur_i      (parse_q),
    .allow_v6_i (allow_v6_q),
    .c_i        (text_byte_i),
    .end_i      (end_mark_i),
    .nxt_o      (parse_d),
    .emit_o     (emit),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q     <= '{phase: iatp_pkg::PH_START, gap_pos: iatp_pkg::NO_GAP, default: '0};
      out_valid_q <= 1'b0;
      allow_v6_q  <= 1'b1;
    end else begin
      if (in_take) parse_q <= parse_d;
      // Advance the result slot: load on a deciding byte, drop once taken.
      if (in_take && emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (psel && penable && pwrite && paddr == iatp_pkg::APB_ADDR_ALLOW_V6)
        allow_v6_q <= pwdata[0];
    end
  end

  // Result payload holds without reset; only loaded with a fresh result.
  always_ff @(posedge clk_i) begin
    if (in_take && emit) res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign is_ipv6_o       = res_q.is_ipv6;
  assign addr_upper_o    = res_q.addr_upper;
  assign addr_lower_o    = res_q.addr_lower;
  assign byte_consumed_o = res_q.byte_consumed;

  assign pready = 1'b1;
  assign prdata = (paddr == iatp_pkg::APB_ADDR_ALLOW_V6) ? {31'd0, allow_v6_q} : 32'd0;

endmodule

// ----- tb/iatp_checker.sv -----
// Scoreboard for the IP address text parser: mirrors the parse, predicts each result and
// compares it with what the block hands out. Depends on iatp_pkg for result_t and codes.
module iatp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  text_byte_i,
  input  logic        end_mark_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic        is_ipv6_i,
  input  logic [63:0] addr_upper_i,
  input  logic [63:0] addr_lower_i,
  input  logic        byte_consumed_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  iatp_pkg::result_t expected_results[$];

  logic             allow_v6;
  iatp_pkg::phase_e phase;
  logic             framed;
  logic [15:0]      words[8];
  logic [3:0]       n_words;
  logic [3:0]       gap_at;
  int               dec_val;
  int               hex_val;
  logic [1:0]       octet;
  logic [31:0]      quad;

  function automatic int nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return 16;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_parse();
    phase = iatp_pkg::PH_START;
    framed = 1'b0;
    for (int i = 0; i < 8; i++) words[i] = '0;
    n_words = '0;
    gap_at = iatp_pkg::NO_GAP;
    dec_val = 0;
    hex_val = 0;
    octet = '0;
    quad = '0;
  endtask

  task automatic produce(logic [1:0] st, logic v6, logic [63:0] up, logic [63:0] lo,
                         logic used);
    iatp_pkg::result_t r;
    r.status = st;
    r.is_ipv6 = v6;
    r.addr_upper = up;
    r.addr_lower = lo;
    r.byte_consumed = used;
    expected_results.push_back(r);
    clear_parse();
  endtask

  task automatic reject(logic [1:0] st);
    produce(st, 1'b0, '0, '0, 1'b0);
  endtask

  // Spread the stored words around the zero run and pack them big-endian.
  task automatic v6_finish(logic used);
    logic [15:0] w;
    logic [63:0] up;
    logic [63:0] lo;
    int n;
    int g;
    n = (n_words > 8) ? 8 : n_words;
    g = gap_at;
    up = '0;
    lo = '0;
    for (int i = 0; i < 8; i++) begin
      if (g >= 8 || i < g) w = words[i];
      else if (i >= 8 - (n - g)) w = words[(i - (8 - n)) & 7];
      else w = '0;
      if (i < 4) up = {up[47:0], w};
      else lo = {lo[47:0], w};
    end
    produce(iatp_pkg::ST_OK, 1'b1, up, lo, used);
  endtask

  task automatic octet_done(logic em, logic [7:0] c, int v);
    if (v > 255) begin
      reject(iatp_pkg::ST_RANGE);
      return;
    end
    quad = quad | (32'(v) << (24 - 8 * octet));
    if (octet == 2'd3) produce(iatp_pkg::ST_OK, 1'b0, '0, {32'd0, quad}, 1'b0);
    else if (em || c != iatp_pkg::CH_DOT) reject(iatp_pkg::ST_SYNTAX);
    else begin
      octet++;
      phase = iatp_pkg::PH_V4_FIRST;
    end
  endtask

  task automatic octet_start(logic em, logic [7:0] c);
    if (em || !is_digit(c)) begin
      reject(iatp_pkg::ST_SYNTAX);
      return;
    end
    dec_val = c - "0";
    phase = (dec_val == 0) ? iatp_pkg::PH_V4_ZERO : iatp_pkg::PH_V4_DEC;
  endtask

  task automatic word_start(logic em, logic [7:0] c);
    if (em || nibble(c) > 15) begin
      reject(iatp_pkg::ST_SYNTAX);
      return;
    end
    hex_val = nibble(c);
    phase = iatp_pkg::PH_V6_WORD;
  endtask

  task automatic word_done(logic em, logic [7:0] c);
    bit gapped;
    bit full;
    gapped = gap_at < 8;
    if (hex_val > 16'hffff) begin
      reject(iatp_pkg::ST_RANGE);
      return;
    end
    if (n_words >= 8 || (gapped && n_words >= 7)) begin
      reject(iatp_pkg::ST_SYNTAX);
      return;
    end
    words[n_words[2:0]] = hex_val[15:0];
    n_words++;
    full = n_words == 8;
    if (em) begin
      if (!framed && (full || gapped)) v6_finish(1'b0);
      else reject(iatp_pkg::ST_SYNTAX);
    end else if (c == iatp_pkg::CH_RBR && framed && (full || gapped)) v6_finish(1'b1);
    else if (full || c != iatp_pkg::CH_COLON) reject(iatp_pkg::ST_SYNTAX);
    else phase = iatp_pkg::PH_V6_SEP;
  endtask

  function automatic int dec_push(int acc, int d);
    int v;
    v = acc * 10 + d;
    return (v > 256) ? 256 : v;
  endfunction

  function automatic int hex_push(int acc, int h);
    int v;
    v = acc * 16 + h;
    return (v > 32'h10000) ? 32'h10000 : v;
  endfunction

  // Undecided start: digits may still turn out to be an octet or a word.
  task automatic scan(logic em, logic [7:0] c, bit seen_digits);
    int h;
    h = nibble(c);
    if (em) reject(iatp_pkg::ST_SYNTAX);
    else if (is_digit(c)) begin
      dec_val = dec_push(dec_val, c - "0");
      hex_val = hex_push(hex_val, h);
      phase = iatp_pkg::PH_SCAN;
    end else if (h <= 15) begin
      hex_val = hex_push(hex_val, h);
      phase = iatp_pkg::PH_V6_WORD;
    end else if (c == iatp_pkg::CH_COLON) begin
      if (seen_digits) word_done(1'b0, c);
      else phase = iatp_pkg::PH_V6_LEAD;
    end else if (c == iatp_pkg::CH_DOT && seen_digits) octet_done(1'b0, c, dec_val);
    else reject(iatp_pkg::ST_SYNTAX);
  endtask

  task automatic parse_char(logic [7:0] c, logic em);
    bit dig;
    bit hx;
    dig = !em && is_digit(c);
    hx = !em && nibble(c) <= 15;
    case (phase)
      iatp_pkg::PH_START: begin
        if (!allow_v6) octet_start(em, c);
        else if (!em && c == iatp_pkg::CH_LBR) begin
          framed = 1'b1;
          phase = iatp_pkg::PH_V6_BEGIN;
        end else scan(em, c, 1'b0);
      end
      iatp_pkg::PH_SCAN: scan(em, c, 1'b1);
      iatp_pkg::PH_V4_FIRST: octet_start(em, c);
      iatp_pkg::PH_V4_ZERO: begin
        if (!em && c == iatp_pkg::CH_X) begin
          hex_val = 0;
          phase = iatp_pkg::PH_V4_HEX0;
        end else if (dig) begin
          dec_val = c - "0";
          phase = iatp_pkg::PH_V4_DEC;
        end else octet_done(em, c, 0);
      end
      iatp_pkg::PH_V4_DEC: begin
        if (dig) dec_val = dec_push(dec_val, c - "0");
        else octet_done(em, c, dec_val);
      end
      iatp_pkg::PH_V4_HEX0: begin
        if (!hx) reject(iatp_pkg::ST_SYNTAX);
        else begin
          hex_val = nibble(c);
          phase = iatp_pkg::PH_V4_HEX;
        end
      end
      iatp_pkg::PH_V4_HEX: begin
        if (hx) hex_val = hex_push(hex_val, nibble(c));
        else octet_done(em, c, hex_val);
      end
      iatp_pkg::PH_V6_BEGIN: begin
        if (!em && c == iatp_pkg::CH_COLON) phase = iatp_pkg::PH_V6_LEAD;
        else word_start(em, c);
      end
      iatp_pkg::PH_V6_LEAD: begin
        if (em || c != iatp_pkg::CH_COLON) reject(iatp_pkg::ST_SYNTAX);
        else begin
          gap_at = '0;
          phase = iatp_pkg::PH_V6_GAP;
        end
      end
      iatp_pkg::PH_V6_WORD: begin
        if (hx) hex_val = hex_push(hex_val, nibble(c));
        else word_done(em, c);
      end
      iatp_pkg::PH_V6_SEP: begin
        if (em) reject(iatp_pkg::ST_SYNTAX);
        else if (c == iatp_pkg::CH_COLON) begin
          if (gap_at < 8) reject(iatp_pkg::ST_SYNTAX);
          else begin
            gap_at = n_words;
            phase = iatp_pkg::PH_V6_GAP;
          end
        end else word_start(em, c);
      end
      iatp_pkg::PH_V6_GAP: begin
        if (em) begin
          if (!framed) v6_finish(1'b0);
          else reject(iatp_pkg::ST_SYNTAX);
        end else if (c == iatp_pkg::CH_RBR && framed) v6_finish(1'b1);
        else word_start(em, c);
      end
      default: clear_parse();
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    iatp_pkg::result_t want;
    if (!rst_ni) begin
      allow_v6 = 1'b1;
      clear_parse();
      expected_results.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t result with nothing pending", $time);
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          if (status_i != want.status)
            report("status", 64'(status_i), 64'(want.status));
          if (is_ipv6_i != want.is_ipv6)
            report("is_ipv6", 64'(is_ipv6_i), 64'(want.is_ipv6));
          if (addr_upper_i != want.addr_upper)
            report("addr_upper", addr_upper_i, want.addr_upper);
          if (addr_lower_i != want.addr_lower)
            report("addr_lower", addr_lower_i, want.addr_lower);
          if (byte_consumed_i != want.byte_consumed)
            report("byte_consumed", 64'(byte_consumed_i), 64'(want.byte_consumed));
        end
      end
      if (in_valid_i && in_ready_i) parse_char(text_byte_i, end_mark_i);
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == iatp_pkg::APB_ADDR_ALLOW_V6)
        allow_v6 = pwdata_i[0];
      outstanding_o = expected_results.size();
    end
  end

endmodule

// ----- tb/ip_address_text_parser_test.sv -----
// Testbench top for the IP address text parser: clock, reset, text stimulus, APB writes.
// Depends on iatp_pkg, ip_address_text_parser and the iatp_checker scoreboard.
module ip_address_text_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int RX_HOLD = 300;

  typedef struct packed {
    logic [7:0] b;
    logic       em;
  } char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        end_mark = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        is_ipv6;
  logic [63:0] addr_upper;
  logic [63:0] addr_lower;
  logic        byte_consumed;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic        paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  char_t text_q[$];
  int    chars_sent = 0;
  bit    calm = 1'b0;      // no idle gaps on either side while set
  bit    rx_hold = 1'b0;   // ask the receiver for one long hold-off

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ip_address_text_parser i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .text_byte_i(text_byte), .end_mark_i(end_mark),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .is_ipv6_o(is_ipv6),
    .addr_upper_o(addr_upper), .addr_lower_o(addr_lower),
    .byte_consumed_o(byte_consumed),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  iatp_checker i_check (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .text_byte_i(text_byte), .end_mark_i(end_mark),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .is_ipv6_i(is_ipv6),
    .addr_upper_i(addr_upper), .addr_lower_i(addr_lower),
    .byte_consumed_i(byte_consumed),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  // Watchdog: give up once nothing has moved for too long.
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
        out_ready <= 1'b0;
        @(negedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Offer one transaction; hold the payload until it is taken.
  task automatic send_char(char_t ch);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    text_byte <= ch.b;
    end_mark <= ch.em;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    chars_sent++;
  endtask

  task automatic play_text();
    while (text_q.size() > 0) send_char(text_q.pop_front());
    in_valid <= 1'b0;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back({s[i], 1'b0});
  endtask

  // End of text: the byte lane carries junk that must be ignored.
  task automatic push_end();
    text_q.push_back({8'($urandom), 1'b1});
  endtask

  function automatic string hex_text(int v, int digits, bit upper);
    string s;
    int n;
    s = "";
    for (int i = digits - 1; i >= 0; i--) begin
      n = (v >> (4 * i)) & 15;
      if (n < 10) s = {s, string'(8'("0" + n))};
      else s = {s, string'(8'((upper ? "A" : "a") + n - 10))};
    end
    return s;
  endfunction

  // Wait for the pipeline to drain, then write the single register.
  task automatic set_allow_v6(bit on);
    wait (outstanding == 0);
    repeat (4) @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= iatp_pkg::APB_ADDR_ALLOW_V6;
    pwdata <= {$urandom() & 32'hffff_fffe} | 32'(on);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic make_v4();
    int v;
    for (int k = 0; k < 4; k++) begin
      if (k > 0) push_str(".");
      case ($urandom_range(0, 7))
        0: push_str($sformatf("%0d", $urandom_range(0, 999)));
        1: push_str($sformatf("0%0d", $urandom_range(0, 255)));
        2, 3: begin
          v = $urandom_range(0, 300);
          push_str({"0x", hex_text(v, $urandom_range(1, 3), $urandom_range(0, 1))});
        end
        default: push_str($sformatf("%0d", $urandom_range(0, 255)));
      endcase
    end
    case ($urandom_range(0, 2))
      0: push_end();
      1: push_str(" ");
      default: push_str("/");
    endcase
  endtask

  task automatic make_v6();
    int n;
    int gp;
    bit gapped;
    bit framed;
    n = $urandom_range(1, 8);
    gapped = $urandom_range(0, 3) != 0;
    gp = $urandom_range(0, n);
    framed = $urandom_range(0, 1);
    if (framed) push_str("[");
    for (int i = 0; i < n; i++) begin
      if (gapped && i == gp) push_str("::");
      else if (i > 0) push_str(":");
      push_str(hex_text($urandom_range(0, 32'hfffff),
                        ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4),
                        $urandom_range(0, 1)));
    end
    if (gapped && gp == n) push_str("::");
    if (framed) push_str("]");
    else push_end();
  endtask

  task automatic make_noise();
    int len;
    len = $urandom_range(1, 6);
    repeat (len) text_q.push_back({8'($urandom), 1'b0});
    push_end();
  endtask

  task automatic random_phase(int n_chars);
    int stop;
    int r;
    stop = chars_sent + n_chars;
    while (chars_sent < stop) begin
      r = $urandom_range(0, 9);
      if (r < 4) make_v4();
      else if (r < 8) make_v6();
      else make_noise();
      // Corrupt a character now and then to reach the error paths.
      if ($urandom_range(0, 9) == 0)
        text_q[$urandom_range(0, text_q.size() - 1)].b = 8'($urandom);
      play_text();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: octet and word extremes, hex octets, zero runs, framing, errors.
    push_str("0.0.0.0"); push_end();
    push_str("255.255.255.255"); push_end();
    push_str("256.1.1.1"); push_end();
    push_str("0x1f.0XFF.00.0x100 ");
    push_str("::"); push_end();
    push_str("[::]");
    push_str("::1"); push_end();
    push_str("1::"); push_end();
    push_str("ffff:2:3:4:5:6:7:FFFF"); push_end();
    push_str("[1:2:3:4:5:6:7:8]");
    push_str("1:2:3:4::5:6:7:8"); push_end();
    push_str("1::2::3"); push_end();
    push_str("10000::"); push_end();
    push_str("1.2.3"); push_end();
    push_str("[1::2"); push_end();
    push_str("12 "); push_end();
    play_text();
    set_allow_v6(1'b0);
    push_str("::1"); push_end();
    push_str("9.8.7.6]");
    play_text();
    set_allow_v6(1'b1);

    // Random, with a calm stretch, a long receiver hold and register changes.
    random_phase(250);
    calm = 1'b1;
    random_phase(100);
    rx_hold = 1'b1;
    random_phase(100);
    calm = 1'b0;
    set_allow_v6(1'b0);
    random_phase(200);
    set_allow_v6(1'b1);
    random_phase(130);

    wait (outstanding == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/iatp_pkg.sv
src/iatp_step.sv
src/ip_address_text_parser.sv
tb/iatp_checker.sv
tb/ip_address_text_parser_test.sv
